FILE: hw/rtl/pctd_pkg.sv
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared constants, types and helpers for the prefix-code table decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int TABLE_DEPTH  = 512;
    localparam int MAX_CODE_LEN = 32;

    localparam int INDEX_W    = 9;
    localparam int SYMBOL_W   = 9;
    localparam int LENGTH_W   = 6;
    localparam int CODE_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int ACTIVE_W   = 10;
    localparam int PEND_LEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int CMP_W      = (PEND_LEN_W > LENGTH_W) ? PEND_LEN_W : LENGTH_W;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;

    localparam int IDX_LSB  = 0;
    localparam int SYM_LSB  = IDX_LSB + INDEX_W;
    localparam int LEN_LSB  = SYM_LSB + SYMBOL_W;
    localparam int CODE_LSB = LEN_LSB + LENGTH_W;
    localparam int BIT_LSB  = CODE_LSB + CODE_W;

    localparam logic [SYMBOL_W-1:0] END_SYMBOL = SYMBOL_W'(256);

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_BIT  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    typedef struct packed
    {
        logic [SYMBOL_W-1:0] symbol;
        logic [LENGTH_W-1:0] length;
        logic [CODE_W-1:0]   code;
    } entry_t;

    typedef struct packed
    {
        logic                  valid;
        logic                  hit;
        logic [ACTIVE_W-1:0]   remaining;
        logic [PEND_LEN_W-1:0] length;
        logic [CODE_W-1:0]     bits;
        logic [SYMBOL_W-1:0]   symbol;
    } token_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] symbol;
        logic              end_of_stream;
        logic              code_error;
    } result_t;

    function automatic logic [CODE_W-1:0] low_mask(input logic [LENGTH_W-1:0] len);
        logic [CODE_W-1:0] m;
        for (int i = 0; i < CODE_W; i++)
        begin
            m[i] = (i < int'(len));
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/prefix_code_table_decoder.sv
// ----------------------------------------------------------------------------
// prefix_code_table_decoder
// Decodes a prefix-coded bit stream against a code table held in a row of
// TABLE_DEPTH cells, one entry per cell. A load item writes one cell. A bit
// item extends the accumulator and sends it down the row as a token that moves
// one cell per cycle; the first active cell whose length and code match marks
// it. A bit item occupies the block until its token has walked the whole cell
// row. A result leaves through an output register, so the next item is taken
// while it waits.
// ----------------------------------------------------------------------------
module prefix_code_table_decoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pctd_pkg::ACTIVE_W-1:0]     cfg_wdata,   // active_entries
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[8:0], entry_symbol[17:9], entry_length[23:18],
    // entry_code[55:24], coded_bit[56], zero[63:57]
    input  logic [pctd_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,     // command[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pctd_pkg::OUT_DATA_W-1:0]   m_tdata,     // symbol[7:0]
    output logic                              m_tlast,     // end_of_stream
    output logic                              m_tuser      // code_error[0]
);

    pctd_pkg::token_t  tok [pctd_pkg::TABLE_DEPTH+1];
    pctd_pkg::entry_t  wr_entry;
    pctd_pkg::result_t result;
    pctd_pkg::cmd_t    cmd;

    logic                          load_accept;
    logic [pctd_pkg::INDEX_W-1:0]  wr_index;
    logic [pctd_pkg::LENGTH_W-1:0] wr_length;

    assign cmd         = pctd_pkg::cmd_t'(s_tuser);
    assign load_accept = s_tvalid && s_tready && (cmd == pctd_pkg::CMD_LOAD);
    assign wr_index    = s_tdata[pctd_pkg::IDX_LSB +: pctd_pkg::INDEX_W];
    assign wr_length   = s_tdata[pctd_pkg::LEN_LSB +: pctd_pkg::LENGTH_W];

    always_comb
    begin
        wr_entry.symbol = s_tdata[pctd_pkg::SYM_LSB +: pctd_pkg::SYMBOL_W];
        wr_entry.length = wr_length;
        wr_entry.code   = s_tdata[pctd_pkg::CODE_LSB +: pctd_pkg::CODE_W]
                        & pctd_pkg::low_mask(wr_length);
    end

    pctd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (cmd),
        .in_bit     (s_tdata[pctd_pkg::BIT_LSB]),
        .tok_inject (tok[0]),
        .tok_exit   (tok[pctd_pkg::TABLE_DEPTH]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    for (genvar i = 0; i < pctd_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        pctd_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (load_accept && (int'(wr_index) == i)),
            .wr_entry (wr_entry),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign m_tdata = result.symbol;
    assign m_tlast = result.end_of_stream;
    assign m_tuser = result.code_error;

endmodule

FILE: hw/rtl/pctd_cell.sv
// ----------------------------------------------------------------------------
// pctd_cell
// One table entry plus one token stage; compares the passing accumulator
// against its entry and marks the first hit.
// ----------------------------------------------------------------------------
module pctd_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  pctd_pkg::entry_t wr_entry,
    input  pctd_pkg::token_t tok_in,
    output pctd_pkg::token_t tok_out
);

    pctd_pkg::entry_t entry_reg;
    pctd_pkg::token_t tok_reg;
    pctd_pkg::token_t tok_next;

    logic active;
    logic len_eq;
    logic code_eq;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg <= wr_entry;
        end
    end

    always_comb
    begin
        active  = (tok_in.remaining != '0);
        len_eq  = (pctd_pkg::CMP_W'(entry_reg.length) == pctd_pkg::CMP_W'(tok_in.length));
        code_eq = (entry_reg.code == tok_in.bits);

        tok_next = tok_in;
        tok_next.remaining = active ? (tok_in.remaining - 1'b1) : '0;
        if (tok_in.valid && !tok_in.hit && active && len_eq && code_eq)
        begin
            tok_next.hit    = 1'b1;
            tok_next.symbol = entry_reg.symbol;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/pctd_ctrl.sv
// ----------------------------------------------------------------------------
// pctd_ctrl
// Accumulator, entry-count register, item sequencing and result register.
// ----------------------------------------------------------------------------
module pctd_ctrl
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pctd_pkg::ACTIVE_W-1:0]    cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  pctd_pkg::cmd_t                   in_cmd,
    input  logic                             in_bit,
    output pctd_pkg::token_t                 tok_inject,
    input  pctd_pkg::token_t                 tok_exit,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pctd_pkg::result_t                out_result
);

    pctd_pkg::state_t state_reg;
    pctd_pkg::state_t state_next;

    logic [pctd_pkg::ACTIVE_W-1:0]   active_reg;
    logic [pctd_pkg::CODE_W-1:0]     bits_reg;
    logic [pctd_pkg::CODE_W-1:0]     bits_next;
    logic [pctd_pkg::PEND_LEN_W-1:0] len_reg;
    logic [pctd_pkg::PEND_LEN_W-1:0] len_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    pctd_pkg::result_t    out_reg;
    pctd_pkg::result_t    out_next;
    pctd_pkg::result_t    hold_reg;
    pctd_pkg::result_t    hold_next;

    logic                              bit_accept;
    logic [pctd_pkg::ACTIVE_W-1:0]     limit;
    logic [pctd_pkg::CODE_W-1:0]       shifted;
    logic [pctd_pkg::PEND_LEN_W-1:0]   len_inc;
    logic                              out_free;
    logic                              res_valid;
    pctd_pkg::result_t                 res;

    assign in_ready   = (state_reg == pctd_pkg::ST_IDLE);
    assign bit_accept = in_valid && in_ready && (in_cmd == pctd_pkg::CMD_BIT);
    assign shifted    = {bits_reg[pctd_pkg::CODE_W-2:0], in_bit};
    assign len_inc    = len_reg + 1'b1;
    assign out_free   = !out_valid_reg || out_ready;
    assign limit      = (int'(active_reg) > pctd_pkg::TABLE_DEPTH)
                      ? pctd_pkg::ACTIVE_W'(pctd_pkg::TABLE_DEPTH) : active_reg;

    always_comb
    begin
        tok_inject           = '0;
        tok_inject.valid     = bit_accept;
        tok_inject.remaining = limit;
        tok_inject.length    = len_inc;
        tok_inject.bits      = shifted;
    end

    always_comb
    begin
        res = '0;
        if (tok_exit.hit)
        begin
            if (tok_exit.symbol == pctd_pkg::END_SYMBOL)
            begin
                res.end_of_stream = 1'b1;
            end
            else if (tok_exit.symbol > pctd_pkg::END_SYMBOL)
            begin
                res.code_error = 1'b1;
            end
            else
            begin
                res.symbol = tok_exit.symbol[pctd_pkg::BYTE_W-1:0];
            end
        end
        else
        begin
            res.code_error = 1'b1;
        end
        res_valid = tok_exit.hit || (int'(len_reg) >= pctd_pkg::MAX_CODE_LEN);
    end

    always_comb
    begin
        state_next     = state_reg;
        bits_next      = bits_reg;
        len_next       = len_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            pctd_pkg::ST_IDLE:
            begin
                if (bit_accept)
                begin
                    bits_next  = shifted;
                    len_next   = len_inc;
                    state_next = pctd_pkg::ST_RUN;
                end
            end
            pctd_pkg::ST_RUN:
            begin
                if (tok_exit.valid)
                begin
                    if (res_valid)
                    begin
                        bits_next = '0;
                        len_next  = '0;
                        if (out_free)
                        begin
                            out_next       = res;
                            out_valid_next = 1'b1;
                            state_next     = pctd_pkg::ST_IDLE;
                        end
                        else
                        begin
                            hold_next  = res;
                            state_next = pctd_pkg::ST_HOLD;
                        end
                    end
                    else
                    begin
                        state_next = pctd_pkg::ST_IDLE;
                    end
                end
            end
            pctd_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = pctd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pctd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pctd_pkg::ST_IDLE;
            active_reg    <= '0;
            bits_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_reg      <= bits_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prefix-code table decoder. Loads code tables
// built as random prefix-free code trees, points the active entry count at
// them and streams codewords, noise bits and stray loads through the input
// stream. A scoreboard class mirrors the table and the bit accumulator,
// predicts every decoded symbol, end-of-stream and code error, and checks
// each result item against the oldest prediction. Both stream sides idle at
// random in rotating modes, and one phase stalls the output long enough to
// back the block up.
// ----------------------------------------------------------------------------
module tb_top;

    import pctd_pkg::*;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES   = 4000;
    localparam int ITEM_TARGET   = 1170;

    class code_table_model;
        logic [SYMBOL_W-1:0] sym_mem  [TABLE_DEPTH];
        logic [LENGTH_W-1:0] len_mem  [TABLE_DEPTH];
        logic [CODE_W-1:0]   code_mem [TABLE_DEPTH];
        logic [CODE_W-1:0]   acc_bits;
        int unsigned         acc_len;
        int unsigned         active;
        result_t             decoded_q[$];
        int                  mismatches;

        function new();
            acc_bits   = '0;
            acc_len    = 0;
            active     = 0;
            mismatches = 0;
        endfunction

        function void accept_item(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                                  input logic [SYMBOL_W-1:0] sym,
                                  input logic [LENGTH_W-1:0] len,
                                  input logic [CODE_W-1:0] code, input logic cbit);
            int unsigned       lim;
            logic [CODE_W-1:0] m;
            result_t           r;
            if (cmd == CMD_LOAD)
            begin
                sym_mem[idx]  = sym;
                len_mem[idx]  = len;
                code_mem[idx] = code;
                return;
            end
            acc_bits = {acc_bits[CODE_W-2:0], cbit};
            acc_len++;
            lim = (active > TABLE_DEPTH) ? TABLE_DEPTH : active;
            for (int i = 0; i < lim; i++)
            begin
                if (len_mem[i] == 0 || len_mem[i] > MAX_CODE_LEN || len_mem[i] != acc_len)
                    continue;
                m = ~({CODE_W{1'b1}} << len_mem[i]);
                if ((code_mem[i] & m) != (acc_bits & m))
                    continue;
                r = '0;
                if (sym_mem[i] == END_SYMBOL)
                    r.end_of_stream = 1'b1;
                else if (sym_mem[i] > END_SYMBOL)
                    r.code_error = 1'b1;
                else
                    r.symbol = sym_mem[i][BYTE_W-1:0];
                decoded_q.insert(decoded_q.size(), r);
                acc_bits = '0;
                acc_len  = 0;
                return;
            end
            if (acc_len >= MAX_CODE_LEN)
            begin
                r = '0;
                r.code_error = 1'b1;
                decoded_q.insert(decoded_q.size(), r);
                acc_bits = '0;
                acc_len  = 0;
            end
        endfunction

        function void check_output(input logic [BYTE_W-1:0] sym, input logic eos,
                                   input logic err);
            result_t want;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected result, actual symbol %0d eos %b error %b",
                         $time, sym, eos, err);
                mismatches++;
                return;
            end
            want = decoded_q.pop_front();
            if (want.symbol !== sym)
            begin
                $display("%0t: symbol expected %0d actual %0d", $time, want.symbol, sym);
                mismatches++;
            end
            if (want.end_of_stream !== eos)
            begin
                $display("%0t: end_of_stream expected %b actual %b",
                         $time, want.end_of_stream, eos);
                mismatches++;
            end
            if (want.code_error !== err)
            begin
                $display("%0t: code_error expected %b actual %b",
                         $time, want.code_error, err);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [ACTIVE_W-1:0]   cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    code_table_model decoder_model = new();

    logic              loaded [TABLE_DEPTH];
    int unsigned       leaf_len[$];
    logic [CODE_W-1:0] leaf_bits[$];
    int                sent_items    = 0;
    int                src_idle      = 0;
    int                sink_stall    = 0;
    int                hold_requests = 0;
    int                hold_served   = 0;
    int                cycles        = 0;

    prefix_code_table_decoder i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            decoder_model.check_output(m_tdata, m_tlast, m_tuser);
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= sink_stall);
        end
    end

    task automatic send_item(input cmd_t cmd, input logic [INDEX_W-1:0] idx,
                             input logic [SYMBOL_W-1:0] sym,
                             input logic [LENGTH_W-1:0] len,
                             input logic [CODE_W-1:0] code, input logic cbit);
        logic [IN_DATA_W-1:0] data;
        data = '0;
        data[IDX_LSB +: INDEX_W]   = idx;
        data[SYM_LSB +: SYMBOL_W]  = sym;
        data[LEN_LSB +: LENGTH_W]  = len;
        data[CODE_LSB +: CODE_W]   = code;
        data[BIT_LSB]              = cbit;
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decoder_model.accept_item(cmd, idx, sym, len, code, cbit);
        if (cmd == CMD_LOAD)
            loaded[idx] = 1'b1;
        sent_items++;
    endtask

    task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [SYMBOL_W-1:0] sym,
                              input logic [LENGTH_W-1:0] len, input logic [CODE_W-1:0] code);
        send_item(CMD_LOAD, idx, sym, len, code, 1'($urandom));
    endtask

    task automatic send_bit(input logic cbit);
        send_item(CMD_BIT, 9'($urandom), 9'($urandom), 6'($urandom), $urandom, cbit);
    endtask

    // drop valid, wait for every predicted result, then let the last walk finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (decoder_model.decoded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_active(input int unsigned n);
        cfg_we    <= 1'b1;
        cfg_wdata <= ACTIVE_W'(n);
        @(posedge clk);
        cfg_we    <= 1'b0;
        decoder_model.active = n;
    endtask

    function automatic logic [SYMBOL_W-1:0] pick_symbol();
        case ($urandom_range(15))
            0:       return END_SYMBOL;
            1:       return SYMBOL_W'($urandom_range(511, 257));
            default: return SYMBOL_W'($urandom_range(255));
        endcase
    endfunction

    function automatic void split_leaf(input int j);
        leaf_bits.insert(leaf_bits.size(), {leaf_bits[j][CODE_W-2:0], 1'b1});
        leaf_len.insert(leaf_len.size(), leaf_len[j] + 1);
        leaf_bits[j] = leaf_bits[j] << 1;
        leaf_len[j]  = leaf_len[j] + 1;
    endfunction

    task automatic build_code(input int n_leaves, input bit deep, input bit gap);
        int j;
        leaf_len.delete();
        leaf_bits.delete();
        leaf_len.insert(leaf_len.size(), 1);
        leaf_bits.insert(leaf_bits.size(), CODE_W'(0));
        leaf_len.insert(leaf_len.size(), 1);
        leaf_bits.insert(leaf_bits.size(), CODE_W'(1));
        while (leaf_len.size() < n_leaves)
        begin
            j = $urandom_range(leaf_len.size() - 1);
            if (leaf_len[j] < MAX_CODE_LEN)
                split_leaf(j);
        end
        if (deep)
            while (leaf_len[0] < MAX_CODE_LEN)
                split_leaf(0);
        if (gap && leaf_len.size() > 2)
        begin
            j = $urandom_range(leaf_len.size() - 1);
            leaf_len.delete(j);
            leaf_bits.delete(j);
        end
    endtask

    task automatic fill_below(input int unsigned n);
        logic [LENGTH_W-1:0] len;
        for (int i = 0; i < n; i++)
        begin
            if (!loaded[i])
            begin
                case ($urandom_range(2))
                    0:       len = '0;
                    1:       len = LENGTH_W'($urandom_range(63, MAX_CODE_LEN + 1));
                    default: len = LENGTH_W'($urandom_range(MAX_CODE_LEN, 1));
                endcase
                load_entry(INDEX_W'(i), pick_symbol(), len, $urandom);
            end
        end
    endtask

    task automatic send_codeword(input int k);
        for (int p = leaf_len[k] - 1; p >= 0; p--)
            send_bit(leaf_bits[k][p]);
    endtask

    task automatic run_phase(input int phase);
        int          n_leaves;
        int unsigned n_active;
        int          n_words;
        case (phase % 4)
            0:       begin src_idle = 0;  sink_stall = 0;  end
            1:       begin src_idle = 47; sink_stall = 0;  end
            2:       begin src_idle = 0;  sink_stall = 47; end
            default: begin src_idle = 14; sink_stall = 14; end
        endcase
        if (phase == 0)
        begin
            // no active entries: every 32nd bit overflows the accumulator
            set_active(0);
            repeat (40) send_bit(1'($urandom));
            settle();
            return;
        end
        n_leaves = (phase == 1) ? 2 : $urandom_range(20, 2);
        build_code(n_leaves, phase > 1 && $urandom_range(3) == 0,
                   phase > 1 && $urandom_range(3) == 0);
        n_active = (phase == 2) ? TABLE_DEPTH : leaf_len.size() + $urandom_range(6);
        if (phase > 2 && $urandom_range(9) == 0)
            n_active = $urandom_range(leaf_len.size(), 1);
        for (int k = 0; k < leaf_len.size(); k++)
            load_entry(INDEX_W'(k), pick_symbol(), LENGTH_W'(leaf_len[k]),
                       ($urandom << leaf_len[k]) | leaf_bits[k]);
        fill_below(n_active);
        settle();
        set_active(n_active);
        if (phase == 1)
            hold_requests <= hold_requests + 1;
        n_words = (phase == 1) ? 16 : $urandom_range(30, 8);
        for (int w = 0; w < n_words && sent_items < ITEM_TARGET; w++)
        begin
            case ($urandom_range(19))
                0:       send_bit(1'($urandom));
                1:       load_entry(INDEX_W'($urandom_range(TABLE_DEPTH - 1)), pick_symbol(),
                                    6'($urandom), $urandom);
                default: send_codeword($urandom_range(leaf_len.size() - 1));
            endcase
        end
        settle();
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
            loaded[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        load_entry(9'd0, 9'd0, 6'd1, 32'hFFFF_FFFE);
        load_entry(9'd1, 9'd255, 6'd2, 32'hFFFF_FFFE);
        load_entry(9'd2, END_SYMBOL, 6'd3, 32'h0000_0006);
        load_entry(9'd3, 9'd257, 6'd4, 32'h0000_000E);
        load_entry(9'd4, 9'd511, 6'd5, 32'h0000_001E);
        load_entry(9'd5, 9'd5, 6'd0, 32'h0000_0000);
        load_entry(9'd6, 9'd6, 6'd33, 32'h0000_003E);
        load_entry(9'd7, 9'd7, 6'd63, 32'hFFFF_FFFF);
        load_entry(9'd8, 9'd99, 6'd1, 32'h0000_0000);
        settle();
        set_active(9);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b0);
        send_bit(1'b1);
        load_entry(INDEX_W'(TABLE_DEPTH - 1), 9'd255, LENGTH_W'(MAX_CODE_LEN), 32'hFFFF_FFFF);
        send_bit(1'b1);
        send_bit(1'b0);
        repeat (3) send_bit(1'b1);
        send_bit(1'b0);
        repeat (4) send_bit(1'b1);
        send_bit(1'b0);
        settle();

        for (int phase = 0; sent_items < ITEM_TARGET; phase++)
            run_phase(phase);

        settle();
        if (decoder_model.mismatches == 0 && decoder_model.decoded_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/pctd_pkg.sv
hw/rtl/pctd_cell.sv
hw/rtl/pctd_ctrl.sv
hw/rtl/prefix_code_table_decoder.sv
tb/tb_top.sv
